// ===== sv/clas_pkg.sv =====
package clas_pkg;

   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 8;
   localparam int COUNT_MAX = 255;

   localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_TAB    = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_QUOTE  = 8'h22;
   localparam logic [BYTE_W-1:0] CHAR_BSLASH = 8'h5C;

   typedef struct packed {
      logic [COUNT_W-1:0] backslashes;
      logic               char_valid;
      logic [BYTE_W-1:0]  out_char;
      logic               arg_end;
   } clas_rsp_type;

   typedef struct packed {
      logic         has_result;
      clas_rsp_type rsp;
   } clas_result_type;

   typedef struct packed {
      logic in_quotes;
      logic quote_pending;
      logic arg_open;
   } clas_status_type;

endpackage

// ===== sv/clas_if.sv =====
interface clas_req_if;
   import clas_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

interface clas_rsp_if;
   import clas_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] backslashes;
   logic               char_valid;
   logic [BYTE_W-1:0]  out_char;
   logic               arg_end;

   modport source (output valid, output backslashes, output char_valid, output out_char,
                   output arg_end, input ready);
   modport sink (input valid, input backslashes, input char_valid, input out_char,
                 input arg_end, output ready);
endinterface

// ===== sv/clas_in_stage.sv =====
module clas_in_stage (
   input  logic                      clock,
   input  logic                      reset,
   clas_req_if.sink                  req_chan,
   input  logic                      step,
   output logic                      byte_valid,
   output logic [clas_pkg::BYTE_W-1:0] byte_data
);
   import clas_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              take;

   assign req_chan.ready = !valid_ff || step;
   assign take = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (step) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_chan.text_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule

// ===== sv/clas_core.sv =====
module clas_core #(
   parameter int MAX_BACKSLASH_RUN = 255
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [clas_pkg::BYTE_W-1:0] byte_data,
   output clas_pkg::clas_result_type   result,
   output clas_pkg::clas_status_type   status
);
   import clas_pkg::*;

   localparam int RUN_W = $clog2(MAX_BACKSLASH_RUN + 1);
   localparam int EXT_W = RUN_W + COUNT_W;

   logic             in_quotes_ff;
   logic             in_quotes_in;
   logic             quote_pending_ff;
   logic             quote_pending_in;
   logic             arg_open_ff;
   logic             arg_open_in;
   logic [RUN_W-1:0] run_ff;
   logic [RUN_W-1:0] run_in;

   logic             iq;
   logic [RUN_W-1:0] count;
   logic [EXT_W-1:0] count_ext;
   logic             valid;
   logic [BYTE_W-1:0] ch;
   logic             arg_end;

   always_comb begin
      in_quotes_in     = in_quotes_ff;
      quote_pending_in = 1'b0;
      arg_open_in      = arg_open_ff;
      run_in           = run_ff;
      iq               = in_quotes_ff;
      count            = '0;
      valid            = 1'b0;
      ch               = CHAR_NUL;
      arg_end          = 1'b0;
      if (quote_pending_ff && byte_data == CHAR_QUOTE) begin
         valid = 1'b1;
         ch    = CHAR_QUOTE;
      end else begin
         if (quote_pending_ff) begin
            iq = 1'b0;
         end
         in_quotes_in = iq;
         priority if (byte_data == CHAR_NUL) begin
            count            = run_ff;
            arg_end          = arg_open_ff;
            in_quotes_in     = 1'b0;
            arg_open_in      = 1'b0;
            run_in           = '0;
            if (!arg_open_ff) begin
               count = '0;
            end
         end else if (byte_data == CHAR_BSLASH) begin
            arg_open_in = 1'b1;
            if (run_ff < RUN_W'(MAX_BACKSLASH_RUN)) begin
               run_in = run_ff + RUN_W'(1);
            end
         end else if (byte_data == CHAR_QUOTE) begin
            run_in      = '0;
            arg_open_in = 1'b1;
            count       = run_ff >> 1;
            if (run_ff[0]) begin
               valid = 1'b1;
               ch    = CHAR_QUOTE;
            end else if (iq) begin
               quote_pending_in = 1'b1;
            end else begin
               in_quotes_in = 1'b1;
            end
         end else if ((byte_data == CHAR_SPACE || byte_data == CHAR_TAB) && !iq) begin
            run_in      = '0;
            arg_open_in = 1'b0;
            if (arg_open_ff) begin
               count   = run_ff;
               arg_end = 1'b1;
            end
         end else begin
            run_in      = '0;
            arg_open_in = 1'b1;
            count       = run_ff;
            valid       = 1'b1;
            ch          = byte_data;
         end
      end
   end

   assign count_ext = EXT_W'(count);

   always_comb begin
      result.rsp.char_valid = valid;
      result.rsp.out_char   = ch;
      result.rsp.arg_end    = arg_end;
      if (count_ext > EXT_W'(COUNT_MAX)) begin
         result.rsp.backslashes = COUNT_W'(COUNT_MAX);
      end else begin
         result.rsp.backslashes = count_ext[COUNT_W-1:0];
      end
      result.has_result = (count != '0) || valid || arg_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quotes_ff     <= 1'b0;
         quote_pending_ff <= 1'b0;
         arg_open_ff      <= 1'b0;
         run_ff           <= '0;
      end else if (step) begin
         in_quotes_ff     <= in_quotes_in;
         quote_pending_ff <= quote_pending_in;
         arg_open_ff      <= arg_open_in;
         run_ff           <= run_in;
      end
   end

   assign status.in_quotes     = in_quotes_ff;
   assign status.quote_pending = quote_pending_ff;
   assign status.arg_open      = arg_open_ff;

endmodule

// ===== sv/clas_rsp_stage.sv =====
module clas_rsp_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  clas_pkg::clas_result_type result,
   output logic                      free,
   clas_rsp_if.source                rsp_chan
);
   import clas_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   clas_rsp_type data_ff;
   logic         load;

   assign free = !valid_ff || rsp_chan.ready;
   assign load = step && result.has_result;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result.rsp;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.backslashes = data_ff.backslashes;
   assign rsp_chan.char_valid  = data_ff.char_valid;
   assign rsp_chan.out_char    = data_ff.out_char;
   assign rsp_chan.arg_end     = data_ff.arg_end;

endmodule

// ===== sv/command_line_argument_splitter.sv =====
// channel   direction  transaction
// req_chan  in         one command line byte, zero ends the line
// rsp_chan  out        backslash count, optional character, end of argument
//
// one byte per cycle sustained while rsp_chan does not stall; a byte passes from
// the input register through the splitter state update into the result register
// bytes that produce nothing are consumed without a transaction on rsp_chan
// reset clears the handshake valids and the splitter state
// a stalled rsp_chan holds its result; req_chan still takes one more byte
module command_line_argument_splitter #(
   parameter int MAX_BACKSLASH_RUN = 255
) (
   input  logic        clock,
   input  logic        reset,
   clas_req_if.sink    req_chan,
   clas_rsp_if.source  rsp_chan
);
   import clas_pkg::*;

   logic              byte_valid;
   logic [BYTE_W-1:0] byte_data;
   logic              free;
   logic              step;
   clas_result_type   result;
   clas_status_type   status;

   assign step = byte_valid && free;

   clas_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .step       (step),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   clas_core #(
      .MAX_BACKSLASH_RUN (MAX_BACKSLASH_RUN)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .byte_data (byte_data),
      .result    (result),
      .status    (status)
   );

   clas_rsp_stage u_rsp (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .result   (result),
      .free     (free),
      .rsp_chan (rsp_chan)
   );

   a_pending_in_quotes: assert property (@(posedge clock) disable iff (reset)
      status.quote_pending |-> (status.in_quotes && status.arg_open))
      else $error("quote lookahead outside an open quoted argument");

   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      (step && byte_data == CHAR_NUL) |=>
         (!status.in_quotes && !status.quote_pending && !status.arg_open))
      else $error("state not cleared at end of line");

   a_end_has_no_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.arg_end) |-> !rsp_chan.char_valid)
      else $error("end of argument carries a character");

   a_blank_char_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.char_valid) |-> (rsp_chan.out_char == CHAR_NUL))
      else $error("character field not zero without a character");

endmodule

// ===== bench/command_line_argument_splitter_tb.sv =====
`timescale 1ns / 1ps

module command_line_argument_splitter_tb;
   import clas_pkg::*;

   localparam int BSLASH_RUN_LIMIT = 255;
   localparam int BYTE_TARGET      = 1500;
   localparam int LONG_HOLD        = 300;
   localparam int IDLE_LIMIT       = 5000;
   localparam int DRAIN_CYCLES     = 20;

   typedef enum logic [1:0] {
      CHECK_MODEL,
      CHECK_SILENT,
      CHECK_FIXED
   } step_check_type;

   typedef struct {
      logic [BYTE_W-1:0] text;
      int                reps;
      step_check_type    check;
      clas_rsp_type      rsp;
   } demo_step_type;

   logic clock;
   logic reset;

   clas_req_if req_chan ();
   clas_rsp_if rsp_chan ();

   command_line_argument_splitter #(
      .MAX_BACKSLASH_RUN(BSLASH_RUN_LIMIT)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // splitter state of the predictor
   logic               quoted;
   logic               quote_waiting;
   logic [COUNT_W-1:0] bs_run;
   logic               arg_started;

   clas_rsp_type  arg_pieces_due[$];
   demo_step_type demo_steps[$];
   int            mismatch_count;
   int            bytes_sent;
   int            idle_cycles;
   bit            send_calm;
   bit            rsp_calm;
   bit            hold_request;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic clas_result_type make_piece(input logic [COUNT_W-1:0] count,
                                                  input logic cv, input logic [BYTE_W-1:0] ch,
                                                  input logic ae);
      clas_result_type r;
      r.has_result         = (count != '0) || cv || ae;
      r.rsp.backslashes    = count;
      r.rsp.char_valid     = cv;
      r.rsp.out_char       = cv ? ch : CHAR_NUL;
      r.rsp.arg_end        = ae;
      return r;
   endfunction

   function automatic void queue_piece(input clas_rsp_type p);
      arg_pieces_due.insert(arg_pieces_due.size(), p);
   endfunction

   function automatic void clear_split_state();
      quoted        = 1'b0;
      quote_waiting = 1'b0;
      bs_run        = '0;
      arg_started   = 1'b0;
   endfunction

   function automatic clas_result_type split_byte(input logic [BYTE_W-1:0] c);
      logic [COUNT_W-1:0] run;
      clas_result_type    r;
      r = make_piece('0, 1'b0, CHAR_NUL, 1'b0);
      if (quote_waiting) begin
         quote_waiting = 1'b0;
         if (c == CHAR_QUOTE) return make_piece('0, 1'b1, CHAR_QUOTE, 1'b0);
         quoted = 1'b0;
      end
      if (c == CHAR_NUL) begin
         if (arg_started) r = make_piece(bs_run, 1'b0, CHAR_NUL, 1'b1);
         clear_split_state();
         return r;
      end
      if (c == CHAR_BSLASH) begin
         arg_started = 1'b1;
         if (bs_run < COUNT_W'(BSLASH_RUN_LIMIT)) bs_run = bs_run + 1'b1;
         return r;
      end
      run    = bs_run;
      bs_run = '0;
      if (c == CHAR_QUOTE) begin
         arg_started = 1'b1;
         if (run[0]) return make_piece(run >> 1, 1'b1, CHAR_QUOTE, 1'b0);
         if (quoted) quote_waiting = 1'b1;
         else quoted = 1'b1;
         return make_piece(run >> 1, 1'b0, CHAR_NUL, 1'b0);
      end
      if ((c == CHAR_SPACE || c == CHAR_TAB) && !quoted) begin
         if (!arg_started) return r;
         arg_started = 1'b0;
         return make_piece(run, 1'b0, CHAR_NUL, 1'b1);
      end
      arg_started = 1'b1;
      return make_piece(run, 1'b1, c, 1'b0);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic void add_step(input logic [BYTE_W-1:0] text, input int reps,
                                    input step_check_type check, input logic [COUNT_W-1:0] bs,
                                    input logic cv, input logic [BYTE_W-1:0] ch,
                                    input logic ae);
      demo_step_type s;
      s.text                = text;
      s.reps                = reps;
      s.check               = check;
      s.rsp.backslashes     = bs;
      s.rsp.char_valid      = cv;
      s.rsp.out_char        = ch;
      s.rsp.arg_end         = ae;
      demo_steps.insert(demo_steps.size(), s);
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] text, input step_check_type check,
                            input clas_rsp_type fixed);
      int              gap;
      clas_result_type got;
      gap = send_calm ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid     <= 1'b1;
      req_chan.text_byte <= text;
      do @(posedge clock); while (!req_chan.ready);
      got = split_byte(text);
      case (check)
         CHECK_MODEL: begin
            if (got.has_result) queue_piece(got.rsp);
         end
         CHECK_FIXED: begin
            queue_piece(fixed);
         end
         default: begin
         end
      endcase
      bytes_sent++;
   endtask

   task automatic send_model(input logic [BYTE_W-1:0] text);
      send_byte(text, CHECK_MODEL, '0);
   endtask

   task automatic send_random_line();
      int len;
      int r;
      int n;
      if ($urandom_range(0, 9) == 0) begin
         // noise, zero bytes may land anywhere
         len = $urandom_range(1, 12);
         repeat (len) send_model(8'($urandom_range(0, 255)));
      end else begin
         len = $urandom_range(0, 16);
         repeat (len) begin
            r = $urandom_range(0, 99);
            if (r < 30) send_model(8'($urandom_range(8'h61, 8'h7A)));
            else if (r < 42) send_model(CHAR_SPACE);
            else if (r < 48) send_model(CHAR_TAB);
            else if (r < 63) send_model(CHAR_QUOTE);
            else if (r < 80) begin
               n = ($urandom_range(0, 99) == 0) ? $urandom_range(250, 300)
                                                : $urandom_range(1, 5);
               repeat (n) send_model(CHAR_BSLASH);
               if ($urandom_range(0, 1) == 1) send_model(CHAR_QUOTE);
            end else send_model(8'($urandom_range(1, 255)));
         end
      end
      send_model(CHAR_NUL);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (arg_pieces_due.size() == 0) begin
            report_mismatch("unexpected transaction, backslashes",
                            int'(rsp_chan.backslashes), -1);
         end else begin
            clas_rsp_type want;
            want = arg_pieces_due.pop_front();
            if (rsp_chan.backslashes !== want.backslashes)
               report_mismatch("backslashes", int'(rsp_chan.backslashes),
                               int'(want.backslashes));
            if (rsp_chan.char_valid !== want.char_valid)
               report_mismatch("char_valid", int'(rsp_chan.char_valid),
                               int'(want.char_valid));
            if (rsp_chan.out_char !== want.out_char)
               report_mismatch("out_char", int'(rsp_chan.out_char), int'(want.out_char));
            if (rsp_chan.arg_end !== want.arg_end)
               report_mismatch("arg_end", int'(rsp_chan.arg_end), int'(want.arg_end));
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver
   initial begin
      int stall_left;
      int g;
      int tick;
      stall_left     = 0;
      tick           = 0;
      rsp_calm       = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = LONG_HOLD;
         end
         if (tick % 200 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (rsp_calm) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            g = pick_gap();
            if (g == 0) begin
               rsp_chan.ready <= 1'b1;
            end else begin
               rsp_chan.ready <= 1'b0;
               stall_left = g - 1;
            end
         end
      end
   end

   // sender
   initial begin
      clas_rsp_type fixed;
      int           calm_until;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.text_byte = '0;
      mismatch_count     = 0;
      bytes_sent         = 0;
      idle_cycles        = 0;
      send_calm          = 1'b0;
      hold_request       = 1'b0;
      clear_split_state();

      // plain argument, separators, empty lines, byte extremes
      add_step(8'h61,       1,   CHECK_FIXED,  8'd0,   1'b1, 8'h61,      1'b0);
      add_step(CHAR_SPACE,  1,   CHECK_FIXED,  8'd0,   1'b0, CHAR_NUL,   1'b1);
      add_step(CHAR_SPACE,  1,   CHECK_SILENT, 8'd0,   1'b0, CHAR_NUL,   1'b0);
      add_step(CHAR_NUL,    1,   CHECK_SILENT, 8'd0,   1'b0, CHAR_NUL,   1'b0);
      add_step(CHAR_NUL,    1,   CHECK_SILENT, 8'd0,   1'b0, CHAR_NUL,   1'b0);
      add_step(8'hFF,       1,   CHECK_FIXED,  8'd0,   1'b1, 8'hFF,      1'b0);
      add_step(8'h01,       1,   CHECK_FIXED,  8'd0,   1'b1, 8'h01,      1'b0);
      // backslash not before a quote
      add_step(CHAR_BSLASH, 1,   CHECK_SILENT, 8'd0,   1'b0, CHAR_NUL,   1'b0);
      add_step(8'h62,       1,   CHECK_FIXED,  8'd1,   1'b1, 8'h62,      1'b0);
      // even run opens quotes, doubled quote inside
      add_step(CHAR_BSLASH, 2,   CHECK_SILENT, 8'd0,   1'b0, CHAR_NUL,   1'b0);
      add_step(CHAR_QUOTE,  1,   CHECK_MODEL,  8'd0,   1'b0, CHAR_NUL,   1'b0);
      add_step(CHAR_SPACE,  1,   CHECK_MODEL,  8'd0,   1'b0, CHAR_NUL,   1'b0);
      add_step(CHAR_QUOTE,  1,   CHECK_MODEL,  8'd0,   1'b0, CHAR_NUL,   1'b0);
      add_step(CHAR_QUOTE,  1,   CHECK_MODEL,  8'd0,   1'b0, CHAR_NUL,   1'b0);
      // odd run gives a literal quote
      add_step(CHAR_BSLASH, 3,   CHECK_SILENT, 8'd0,   1'b0, CHAR_NUL,   1'b0);
      add_step(CHAR_QUOTE,  1,   CHECK_MODEL,  8'd0,   1'b0, CHAR_NUL,   1'b0);
      add_step(CHAR_QUOTE,  1,   CHECK_MODEL,  8'd0,   1'b0, CHAR_NUL,   1'b0);
      add_step(CHAR_TAB,    1,   CHECK_MODEL,  8'd0,   1'b0, CHAR_NUL,   1'b0);
      // empty quoted argument
      add_step(CHAR_QUOTE,  1,   CHECK_MODEL,  8'd0,   1'b0, CHAR_NUL,   1'b0);
      add_step(CHAR_QUOTE,  1,   CHECK_MODEL,  8'd0,   1'b0, CHAR_NUL,   1'b0);
      add_step(CHAR_SPACE,  1,   CHECK_FIXED,  8'd0,   1'b0, CHAR_NUL,   1'b1);
      // line ends inside quotes
      add_step(CHAR_QUOTE,  1,   CHECK_MODEL,  8'd0,   1'b0, CHAR_NUL,   1'b0);
      add_step(8'h80,       1,   CHECK_MODEL,  8'd0,   1'b0, CHAR_NUL,   1'b0);
      add_step(CHAR_NUL,    1,   CHECK_FIXED,  8'd0,   1'b0, CHAR_NUL,   1'b1);
      // saturated backslash runs
      add_step(CHAR_BSLASH, 300, CHECK_SILENT, 8'd0,   1'b0, CHAR_NUL,   1'b0);
      add_step(CHAR_QUOTE,  1,   CHECK_FIXED,  8'd127, 1'b1, CHAR_QUOTE, 1'b0);
      add_step(CHAR_BSLASH, 300, CHECK_SILENT, 8'd0,   1'b0, CHAR_NUL,   1'b0);
      add_step(CHAR_NUL,    1,   CHECK_FIXED,  8'd255, 1'b0, CHAR_NUL,   1'b1);
      // line ends with a quote pending
      add_step(CHAR_QUOTE,  2,   CHECK_MODEL,  8'd0,   1'b0, CHAR_NUL,   1'b0);
      add_step(CHAR_NUL,    1,   CHECK_FIXED,  8'd0,   1'b0, CHAR_NUL,   1'b1);

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      foreach (demo_steps[i]) begin
         fixed = demo_steps[i].rsp;
         repeat (demo_steps[i].reps) send_byte(demo_steps[i].text, demo_steps[i].check, fixed);
      end

      // back-to-back bytes against a long receiver hold-off
      send_calm    = 1'b1;
      hold_request = 1'b1;
      calm_until   = bytes_sent + 300;
      while (bytes_sent < calm_until) send_random_line();

      while (bytes_sent < BYTE_TARGET) begin
         send_calm = ($urandom_range(0, 7) == 0);
         send_random_line();
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (arg_pieces_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
